// File: src/psue_pkg.sv
`default_nettype none

package psue_pkg;

    // Default swarm size.
    localparam int PARTICLES_DEF  = 64;
    localparam int DIMENSIONS_DEF = 5;

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int PART_W  = 6;
    localparam int DIM_W   = 3;
    localparam int RAND_W  = 16;
    localparam int COST_W  = 32;
    localparam int COORD_W = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 1;

    // Reset values of the bound registers, Q8.16.
    localparam logic [COORD_W-1:0] LOWER_BOUND_RST = 24'd3277;
    localparam logic [COORD_W-1:0] UPPER_BOUND_RST = 24'd65536;

    // Item codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_START     = 3'd0,
        FUNC_SEED      = 3'd1,
        FUNC_MOVE      = 3'd2,
        FUNC_SEED_COST = 3'd3,
        FUNC_MOVE_COST = 3'd4
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_BOUND = 1'd0,
        REG_UPPER_BOUND = 1'd1
    } reg_idx_t;

endpackage

`default_nettype wire

// File: src/psue_ram.sv
`default_nettype none

module psue_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; a read at the written
    // address returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/particle_swarm_update_engine_core.sv
// Particle swarm update engine.
// Items arrive on the input channel (in_valid / in_stall) and each one gives
// exactly one result on the output channel (out_valid / out_stall). A transfer
// takes place at a rising edge where valid is high and stall is low.
// The particle rows sit in one small RAM per dimension and memory kind
// (position, velocity, personal best), plus one RAM of personal costs; the
// global best row and cost are registers.
// The RAM rows are read as the item is taken, the update is worked out in the
// following cycle and the result enters the output register as the item
// advances. One item per cycle is sustained while out_stall is low, set by the
// single read and write port of each RAM; a write in one cycle is forwarded
// to the item read at the same edge.
// When the receiver stalls, the result is held and one further item may wait
// in the input stage; beyond that in_stall is raised.
// Reset sets the bounds to their defaults and the global best cost to all ones
// and empties both stages; RAM contents are undefined until written.
// Bound registers are written through cfg_write / cfg_index / cfg_data; the
// user must do so only while the engine is idle, the block does not enforce it.
`default_nettype none

module particle_swarm_update_engine_core
    import psue_pkg::*;
#(
    parameter int PARTICLES  = PARTICLES_DEF,
    parameter int DIMENSIONS = DIMENSIONS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [FUNC_W-1:0]    func,
    input  wire logic [PART_W-1:0]    particle,
    input  wire logic [DIM_W-1:0]     dimension,
    input  wire logic [RAND_W-1:0]    rand_a,
    input  wire logic [RAND_W-1:0]    rand_b,
    input  wire logic [COST_W-1:0]    cost,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [COORD_W-1:0]        position,
    output logic [COORD_W-1:0]        best_position,
    output logic [COST_W-1:0]         best_cost,
    output logic                      personal_improved,
    output logic                      global_improved
);

    localparam int AW     = $clog2(PARTICLES);
    localparam int PROD_W = COORD_W + RAND_W + 2;
    localparam int ACC_W  = PROD_W + 2;
    localparam int STEP_W = ACC_W - RAND_W;
    localparam int VS_W   = STEP_W + 1;
    localparam int X_W    = COORD_W + 2;

    // Bound registers
    logic [COORD_W-1:0] lower_bound_reg;
    logic [COORD_W-1:0] upper_bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= LOWER_BOUND_RST;
            upper_bound_reg <= UPPER_BOUND_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOWER_BOUND: lower_bound_reg <= cfg_data;
                REG_UPPER_BOUND: upper_bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and stage control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic in_take;
    logic wr_go;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;
    assign wr_go    = s1_valid_reg && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input register
    logic [FUNC_W-1:0] func_reg;
    logic [PART_W-1:0] particle_reg;
    logic [DIM_W-1:0]  dimension_reg;
    logic [RAND_W-1:0] rand_a_reg;
    logic [RAND_W-1:0] rand_b_reg;
    logic [COST_W-1:0] cost_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg      <= func;
            particle_reg  <= particle;
            dimension_reg <= dimension;
            rand_a_reg    <= rand_a;
            rand_b_reg    <= rand_b;
            cost_reg      <= cost;
        end
    end

    // Row addresses
    logic [PART_W+AW-1:0] in_addr_ext;
    logic [PART_W+AW-1:0] s1_addr_ext;
    logic [AW-1:0]        in_addr;
    logic [AW-1:0]        s1_addr;

    assign in_addr_ext = {{AW{1'b0}}, particle};
    assign s1_addr_ext = {{AW{1'b0}}, particle_reg};
    assign in_addr     = in_addr_ext[AW-1:0];
    assign s1_addr     = s1_addr_ext[AW-1:0];

    // Row memories, one RAM per dimension
    logic [COORD_W-1:0]    pos_rd  [DIMENSIONS];
    logic [COORD_W-1:0]    vel_rd  [DIMENSIONS];
    logic [COORD_W-1:0]    pb_rd   [DIMENSIONS];
    logic [DIMENSIONS-1:0] pos_we;
    logic [DIMENSIONS-1:0] vel_we;
    logic [DIMENSIONS-1:0] pb_we;
    logic [COORD_W-1:0]    pos_wdata;
    logic [COORD_W-1:0]    vel_wdata;
    logic [COORD_W-1:0]    pb_wdata [DIMENSIONS];
    logic [COST_W-1:0]     pc_rd;
    logic                  pc_we;

    for (genvar j = 0; j < DIMENSIONS; j++)
    begin : g_lane
        psue_ram #(.WIDTH(COORD_W), .DEPTH(PARTICLES)) u_pos_ram (
            .clk   (clk),
            .we    (pos_we[j]),
            .waddr (s1_addr),
            .wdata (pos_wdata),
            .re    (in_take),
            .raddr (in_addr),
            .rdata (pos_rd[j])
        );
        psue_ram #(.WIDTH(COORD_W), .DEPTH(PARTICLES)) u_vel_ram (
            .clk   (clk),
            .we    (vel_we[j]),
            .waddr (s1_addr),
            .wdata (vel_wdata),
            .re    (in_take),
            .raddr (in_addr),
            .rdata (vel_rd[j])
        );
        psue_ram #(.WIDTH(COORD_W), .DEPTH(PARTICLES)) u_pb_ram (
            .clk   (clk),
            .we    (pb_we[j]),
            .waddr (s1_addr),
            .wdata (pb_wdata[j]),
            .re    (in_take),
            .raddr (in_addr),
            .rdata (pb_rd[j])
        );
    end

    psue_ram #(.WIDTH(COST_W), .DEPTH(PARTICLES)) u_pc_ram (
        .clk   (clk),
        .we    (pc_we),
        .waddr (s1_addr),
        .wdata (cost_reg),
        .re    (in_take),
        .raddr (in_addr),
        .rdata (pc_rd)
    );

    // Forwarding of the write made at the edge the current item was read
    logic [AW-1:0]         fwd_addr_reg;
    logic [DIMENSIONS-1:0] fwd_pos_en_reg;
    logic [DIMENSIONS-1:0] fwd_vel_en_reg;
    logic [DIMENSIONS-1:0] fwd_pb_en_reg;
    logic                  fwd_pc_en_reg;
    logic [COORD_W-1:0]    fwd_pos_data_reg;
    logic [COORD_W-1:0]    fwd_vel_data_reg;
    logic [COORD_W-1:0]    fwd_pb_data_reg [DIMENSIONS];
    logic [COST_W-1:0]     fwd_pc_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_pos_en_reg <= '0;
            fwd_vel_en_reg <= '0;
            fwd_pb_en_reg  <= '0;
            fwd_pc_en_reg  <= 1'b0;
        end
        else if (in_take)
        begin
            fwd_pos_en_reg <= pos_we;
            fwd_vel_en_reg <= vel_we;
            fwd_pb_en_reg  <= pb_we;
            fwd_pc_en_reg  <= pc_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            fwd_addr_reg     <= s1_addr;
            fwd_pos_data_reg <= pos_wdata;
            fwd_vel_data_reg <= vel_wdata;
            fwd_pb_data_reg  <= pb_wdata;
            fwd_pc_data_reg  <= cost_reg;
        end
    end

    logic               fwd_hit;
    logic [COORD_W-1:0] pos_row [DIMENSIONS];
    logic [COORD_W-1:0] vel_row [DIMENSIONS];
    logic [COORD_W-1:0] pb_row  [DIMENSIONS];
    logic [COST_W-1:0]  pc_row;

    assign fwd_hit = (fwd_addr_reg == s1_addr);

    always_comb
    begin
        for (int j = 0; j < DIMENSIONS; j++)
        begin
            pos_row[j] = (fwd_hit && fwd_pos_en_reg[j]) ? fwd_pos_data_reg : pos_rd[j];
            vel_row[j] = (fwd_hit && fwd_vel_en_reg[j]) ? fwd_vel_data_reg : vel_rd[j];
            pb_row[j]  = (fwd_hit && fwd_pb_en_reg[j]) ? fwd_pb_data_reg[j] : pb_rd[j];
        end
        pc_row = (fwd_hit && fwd_pc_en_reg) ? fwd_pc_data_reg : pc_rd;
    end

    // Global best row and cost
    logic [COORD_W-1:0] gbest_reg  [DIMENSIONS];
    logic [COORD_W-1:0] gbest_next [DIMENSIONS];
    logic [COST_W-1:0]  gcost_reg;
    logic [COST_W-1:0]  gcost_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcost_reg <= '1;
        end
        else if (wr_go)
        begin
            gcost_reg <= gcost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            gbest_reg <= gbest_next;
        end
    end

    // Range checks and selection of the addressed coordinate
    logic                  p_ok;
    logic                  d_ok;
    logic [DIMENSIONS-1:0] lane_sel;
    logic [COORD_W-1:0]    pos_d;
    logic [COORD_W-1:0]    vel_d;
    logic [COORD_W-1:0]    pb_d;
    logic [COORD_W-1:0]    gb_d;

    assign p_ok = (32'(particle_reg) < 32'(PARTICLES));
    assign d_ok = (32'(dimension_reg) < 32'(DIMENSIONS));

    always_comb
    begin
        pos_d = '0;
        vel_d = '0;
        pb_d  = '0;
        gb_d  = '0;
        for (int j = 0; j < DIMENSIONS; j++)
        begin
            lane_sel[j] = (32'(dimension_reg) == 32'(j));
            if (lane_sel[j])
            begin
                pos_d = pos_row[j];
                vel_d = vel_row[j];
                pb_d  = pb_row[j];
                gb_d  = gbest_reg[j];
            end
        end
    end

    // Seeding: lower + floor((upper - lower) * r / 65536)
    logic signed [COORD_W:0]   span;
    logic signed [RAND_W:0]    ra_s;
    logic signed [RAND_W:0]    rb_s;
    logic signed [PROD_W-1:0]  seed_prod;
    logic signed [X_W-1:0]     seed_sum;
    logic [COORD_W-1:0]        seed_val;

    assign span      = $signed({1'b0, upper_bound_reg}) - $signed({1'b0, lower_bound_reg});
    assign ra_s      = $signed({1'b0, rand_a_reg});
    assign rb_s      = $signed({1'b0, rand_b_reg});
    assign seed_prod = PROD_W'(span * ra_s);
    assign seed_sum  = $signed({2'b00, lower_bound_reg}) + $signed(seed_prod[PROD_W-1:RAND_W]);
    assign seed_val  = seed_sum[COORD_W-1:0];

    // Move: velocity update with saturation, then position clamp
    logic signed [COORD_W:0]  diff_p;
    logic signed [COORD_W:0]  diff_g;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_g;
    logic signed [ACC_W-1:0]  acc;
    logic signed [STEP_W-1:0] step;
    logic signed [VS_W-1:0]   vel_sum;
    logic [COORD_W-1:0]       vel_new;
    logic signed [X_W-1:0]    x_sum;
    logic signed [X_W-1:0]    x_low;
    logic signed [X_W-1:0]    lb_s;
    logic signed [X_W-1:0]    ub_s;
    logic [COORD_W-1:0]       pos_move;

    assign diff_p  = $signed({1'b0, pb_d}) - $signed({1'b0, pos_d});
    assign diff_g  = $signed({1'b0, gb_d}) - $signed({1'b0, pos_d});
    assign prod_p  = PROD_W'(diff_p * ra_s);
    assign prod_g  = PROD_W'(diff_g * rb_s);
    assign acc     = (ACC_W'(prod_p) + ACC_W'(prod_g)) <<< 1;
    assign step    = acc[ACC_W-1:RAND_W];
    assign vel_sum = VS_W'(step) + VS_W'($signed(vel_d));

    always_comb
    begin
        if ((&vel_sum[VS_W-1:COORD_W-1]) || !(|vel_sum[VS_W-1:COORD_W-1]))
        begin
            vel_new = vel_sum[COORD_W-1:0];
        end
        else if (vel_sum[VS_W-1])
        begin
            vel_new = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            vel_new = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    assign lb_s  = $signed({2'b00, lower_bound_reg});
    assign ub_s  = $signed({2'b00, upper_bound_reg});
    assign x_sum = $signed({2'b00, pos_d}) + X_W'($signed(vel_new));
    assign x_low = (x_sum < lb_s) ? lb_s : x_sum;

    always_comb
    begin
        if (x_low > ub_s)
        begin
            pos_move = upper_bound_reg;
        end
        else
        begin
            pos_move = x_low[COORD_W-1:0];
        end
    end

    // Item decode: memory writes, global best update and result fields
    logic               pos_sel_we;
    logic               vel_sel_we;
    logic               pb_sel_we;
    logic               pb_row_we;
    logic               pc_do;
    logic               gbest_take;
    logic               take_pos_row;
    logic [COORD_W-1:0] pos_res;
    logic               pimp;
    logic               gimp;

    always_comb
    begin
        pos_sel_we   = 1'b0;
        vel_sel_we   = 1'b0;
        pb_sel_we    = 1'b0;
        pb_row_we    = 1'b0;
        pc_do        = 1'b0;
        gbest_take   = 1'b0;
        take_pos_row = 1'b0;
        pos_wdata    = seed_val;
        vel_wdata    = '0;
        gcost_next   = gcost_reg;
        pos_res      = '0;
        pimp         = 1'b0;
        gimp         = 1'b0;
        case (func_reg)
            FUNC_START:
            begin
                gcost_next = '1;
            end
            FUNC_SEED:
            begin
                if (p_ok && d_ok)
                begin
                    pos_sel_we = 1'b1;
                    vel_sel_we = 1'b1;
                    pb_sel_we  = 1'b1;
                    pos_res    = seed_val;
                end
            end
            FUNC_MOVE:
            begin
                pos_wdata = pos_move;
                vel_wdata = vel_new;
                if (p_ok && d_ok)
                begin
                    pos_sel_we = 1'b1;
                    vel_sel_we = 1'b1;
                    pos_res    = pos_move;
                end
            end
            FUNC_SEED_COST:
            begin
                if (p_ok)
                begin
                    pc_do = 1'b1;
                    pimp  = 1'b1;
                    if (d_ok)
                    begin
                        pos_res = pos_d;
                    end
                    if (cost_reg < gcost_reg)
                    begin
                        gcost_next = cost_reg;
                        gbest_take = 1'b1;
                        gimp       = 1'b1;
                    end
                end
            end
            FUNC_MOVE_COST:
            begin
                take_pos_row = 1'b1;
                if (p_ok)
                begin
                    if (d_ok)
                    begin
                        pos_res = pos_d;
                    end
                    if (cost_reg < pc_row)
                    begin
                        pc_do     = 1'b1;
                        pb_row_we = 1'b1;
                        pimp      = 1'b1;
                        if (cost_reg < gcost_reg)
                        begin
                            gcost_next = cost_reg;
                            gbest_take = 1'b1;
                            gimp       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Per-lane write enables and data; a move cost copies the position row
    always_comb
    begin
        for (int j = 0; j < DIMENSIONS; j++)
        begin
            pos_we[j]   = wr_go && pos_sel_we && lane_sel[j];
            vel_we[j]   = wr_go && vel_sel_we && lane_sel[j];
            pb_we[j]    = wr_go && ((pb_sel_we && lane_sel[j]) || pb_row_we);
            pb_wdata[j] = take_pos_row ? pos_row[j] : seed_val;
            if (gbest_take)
            begin
                gbest_next[j] = take_pos_row ? pos_row[j] : pb_row[j];
            end
            else
            begin
                gbest_next[j] = gbest_reg[j];
            end
        end
        pc_we = wr_go && pc_do;
    end

    // Best coordinate of the addressed dimension after this item
    logic [COORD_W-1:0] best_res;

    always_comb
    begin
        best_res = '0;
        for (int j = 0; j < DIMENSIONS; j++)
        begin
            if (lane_sel[j])
            begin
                best_res = gbest_next[j];
            end
        end
    end

    // Output register
    logic [COORD_W-1:0] position_reg;
    logic [COORD_W-1:0] best_position_reg;
    logic [COST_W-1:0]  best_cost_reg;
    logic               personal_improved_reg;
    logic               global_improved_reg;

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            position_reg          <= pos_res;
            best_position_reg     <= d_ok ? best_res : '0;
            best_cost_reg         <= gcost_next;
            personal_improved_reg <= pimp;
            global_improved_reg   <= gimp;
        end
    end

    assign out_valid         = out_valid_reg;
    assign position          = position_reg;
    assign best_position     = best_position_reg;
    assign best_cost         = best_cost_reg;
    assign personal_improved = personal_improved_reg;
    assign global_improved   = global_improved_reg;

endmodule

`default_nettype wire

// File: src/psue_checker.sv
`default_nettype none

module psue_checker
    import psue_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [COORD_W-1:0]   position,
    input wire logic [COST_W-1:0]    best_cost,
    input wire logic                 personal_improved,
    input wire logic                 global_improved
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its coordinate.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(position))
        else $error("result changed while stalled");

    // The input side only stalls when a result is waiting and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // A new global best is always also a new personal best.
    a_global_needs_personal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && global_improved |-> personal_improved)
        else $error("global best replaced without a personal improvement");

    // An improved global cost is strictly below all ones.
    a_global_cost_lower: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && global_improved |-> best_cost != '1)
        else $error("global improvement reported with the infeasible cost");

endmodule

bind particle_swarm_update_engine_core psue_checker u_psue_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .position          (position),
    .best_cost         (best_cost),
    .personal_improved (personal_improved),
    .global_improved   (global_improved)
);

`default_nettype wire

// File: sim/particle_swarm_update_engine_core_tb.sv
`timescale 1ns / 1ps

module particle_swarm_update_engine_core_tb
    import psue_pkg::*;
();

    localparam int     NP          = PARTICLES_DEF;
    localparam int     ND          = DIMENSIONS_DEF;
    localparam longint SPEED_MAX   = 64'sd8388607;
    localparam longint SPEED_MIN   = -64'sd8388608;
    localparam int     SETTLE      = 4;
    localparam int     CYCLE_LIMIT = 200000;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [PART_W-1:0]  particle;
        logic [DIM_W-1:0]   dimension;
        logic [RAND_W-1:0]  rand_a;
        logic [RAND_W-1:0]  rand_b;
        logic [COST_W-1:0]  cost;
    } swarm_item_t;

    typedef struct {
        logic [COORD_W-1:0] pos;
        logic [COORD_W-1:0] bpos;
        bit                 bpos_known;
        logic [COST_W-1:0]  bcost;
        logic               pimp;
        logic               gimp;
    } swarm_result_t;

    typedef struct {
        swarm_item_t   item;
        bit            typed;
        swarm_result_t res;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func = '0;
    logic [PART_W-1:0]    particle = '0;
    logic [DIM_W-1:0]     dimension = '0;
    logic [RAND_W-1:0]    rand_a = '0;
    logic [RAND_W-1:0]    rand_b = '0;
    logic [COST_W-1:0]    cost = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COORD_W-1:0]   position;
    logic [COORD_W-1:0]   best_position;
    logic [COST_W-1:0]    best_cost;
    logic                 personal_improved;
    logic                 global_improved;

    // Swarm state as the engine should hold it.
    logic [COORD_W-1:0] pos_mem   [NP][ND];
    longint             vel_mem   [NP][ND];
    logic [COORD_W-1:0] pbest_mem [NP][ND];
    logic [COST_W-1:0]  pcost_mem [NP];
    logic [COORD_W-1:0] gbest_row [ND];
    logic [COST_W-1:0]  gcost = '1;
    logic [COORD_W-1:0] lo_bound = LOWER_BOUND_RST;
    logic [COORD_W-1:0] hi_bound = UPPER_BOUND_RST;

    // Which entries have been written so far.
    bit seeded    [NP][ND];
    bit pcost_set [NP];
    bit gbest_set = 1'b0;

    swarm_result_t awaited_results[$];
    swarm_result_t oldest;
    plan_row_t     directed_plan[$];
    int            errors = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    particle_swarm_update_engine_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .particle          (particle),
        .dimension         (dimension),
        .rand_a            (rand_a),
        .rand_b            (rand_b),
        .cost              (cost),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .position          (position),
        .best_position     (best_position),
        .best_cost         (best_cost),
        .personal_improved (personal_improved),
        .global_improved   (global_improved)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Global best takes over the personal best row of one particle.
    task automatic adopt_global(input int p, input logic [COST_W-1:0] c);
        int j;
        gcost = c;
        for (j = 0; j < ND; j++)
            gbest_row[j] = pbest_mem[p][j];
        gbest_set = 1'b1;
    endtask

    // Applies one item to the swarm state and works out its result.
    task automatic swarm_update(input swarm_item_t it, output swarm_result_t r);
        int     p;
        int     d;
        int     j;
        bit     d_ok;
        longint lo;
        longint hi;
        longint ra;
        longint rb;
        longint x;
        longint acc;
        longint v;
        p    = int'(it.particle);
        d    = int'(it.dimension);
        d_ok = d < ND;
        lo   = longint'(lo_bound);
        hi   = longint'(hi_bound);
        ra   = longint'(it.rand_a);
        rb   = longint'(it.rand_b);
        r.pimp = 1'b0;
        r.gimp = 1'b0;

        case (it.func)
            FUNC_START:
            begin
                gcost = '1;
            end
            FUNC_SEED:
            begin
                if (d_ok)
                begin
                    x = lo + (((hi - lo) * ra) >>> 16);
                    pos_mem[p][d]   = x[COORD_W-1:0];
                    pbest_mem[p][d] = x[COORD_W-1:0];
                    vel_mem[p][d]   = 0;
                    seeded[p][d]    = 1'b1;
                end
            end
            FUNC_MOVE:
            begin
                if (d_ok)
                begin
                    x   = longint'(pos_mem[p][d]);
                    acc = 2 * ra * (longint'(pbest_mem[p][d]) - x)
                        + 2 * rb * (longint'(gbest_row[d]) - x);
                    v = vel_mem[p][d] + (acc >>> 16);
                    if (v > SPEED_MAX)
                        v = SPEED_MAX;
                    if (v < SPEED_MIN)
                        v = SPEED_MIN;
                    vel_mem[p][d] = v;
                    x = x + v;
                    // The upper clamp comes last, so inverted bounds give the upper one.
                    if (x < lo)
                        x = lo;
                    if (x > hi)
                        x = hi;
                    pos_mem[p][d] = x[COORD_W-1:0];
                end
            end
            FUNC_SEED_COST:
            begin
                pcost_mem[p] = it.cost;
                pcost_set[p] = 1'b1;
                r.pimp = 1'b1;
                if (it.cost < gcost)
                begin
                    adopt_global(p, it.cost);
                    r.gimp = 1'b1;
                end
            end
            FUNC_MOVE_COST:
            begin
                if (it.cost < pcost_mem[p])
                begin
                    pcost_mem[p] = it.cost;
                    for (j = 0; j < ND; j++)
                        pbest_mem[p][j] = pos_mem[p][j];
                    r.pimp = 1'b1;
                    if (it.cost < gcost)
                    begin
                        adopt_global(p, it.cost);
                        r.gimp = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        r.pos = (it.func >= FUNC_SEED && it.func <= FUNC_MOVE_COST && d_ok) ?
                pos_mem[p][d] : '0;
        r.bpos       = d_ok ? gbest_row[d] : '0;
        r.bpos_known = !d_ok || gbest_set;
        r.bcost      = gcost;
    endtask

    // One row of the directed table; typed rows carry their own expected result.
    function automatic void add_row(
        input logic [FUNC_W-1:0]  f,
        input logic [PART_W-1:0]  p,
        input logic [DIM_W-1:0]   d,
        input logic [RAND_W-1:0]  ra,
        input logic [RAND_W-1:0]  rb,
        input logic [COST_W-1:0]  c,
        input bit                 typed = 1'b0,
        input logic [COORD_W-1:0] e_pos = '0,
        input logic [COORD_W-1:0] e_bpos = '0,
        input logic [COST_W-1:0]  e_bcost = '1,
        input logic               e_pimp = 1'b0,
        input logic               e_gimp = 1'b0
    );
        plan_row_t row;
        row.item.func      = f;
        row.item.particle  = p;
        row.item.dimension = d;
        row.item.rand_a    = ra;
        row.item.rand_b    = rb;
        row.item.cost      = c;
        row.typed          = typed;
        row.res.pos        = e_pos;
        row.res.bpos       = e_bpos;
        row.res.bpos_known = 1'b1;
        row.res.bcost      = e_bcost;
        row.res.pimp       = e_pimp;
        row.res.gimp       = e_gimp;
        directed_plan.push_back(row);
    endfunction

    // Random item that never reads a swarm entry before it has been written.
    function automatic swarm_item_t pick_item();
        swarm_item_t it;
        int          p;
        int          d;
        int          sel;
        int          j;
        int          gap_dim;
        bit          row_full;
        p   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NP - 1) : $urandom_range(0, 7);
        d   = ($urandom_range(0, 9) == 0) ? $urandom_range(ND, 7) : $urandom_range(0, ND - 1);
        sel = $urandom_range(0, 99);
        if (sel < 3)
            it.func = FUNC_START;
        else if (sel < 6)
            it.func = FUNC_W'($urandom_range(5, 7));
        else if (sel < 30)
            it.func = FUNC_SEED;
        else if (sel < 65)
            it.func = FUNC_MOVE;
        else if (sel < 78)
            it.func = FUNC_SEED_COST;
        else
            it.func = FUNC_MOVE_COST;

        row_full = 1'b1;
        gap_dim  = 0;
        for (j = ND - 1; j >= 0; j--)
        begin
            if (!seeded[p][j])
            begin
                row_full = 1'b0;
                gap_dim  = j;
            end
        end

        // Fall back to the step that the chosen one depends on.
        if (it.func == FUNC_MOVE && d < ND && !(seeded[p][d] && gbest_set))
            it.func = FUNC_SEED;
        if (it.func == FUNC_MOVE_COST && !pcost_set[p])
            it.func = FUNC_SEED_COST;
        if (it.func == FUNC_SEED_COST && !row_full)
        begin
            it.func = FUNC_SEED;
            d       = gap_dim;
        end
        if (!gbest_set && it.func != FUNC_SEED)
            d = $urandom_range(ND, 7);

        it.particle  = PART_W'(p);
        it.dimension = DIM_W'(d);
        it.rand_a    = ($urandom_range(0, 9) == 0) ?
                       ($urandom_range(0, 1) ? '1 : '0) : RAND_W'($urandom);
        it.rand_b    = ($urandom_range(0, 9) == 0) ?
                       ($urandom_range(0, 1) ? '1 : '0) : RAND_W'($urandom);
        case ($urandom_range(0, 7))
            0:       it.cost = '0;
            1:       it.cost = '1;
            2, 3:    it.cost = $urandom_range(0, 1000);
            default: it.cost = $urandom;
        endcase
        return it;
    endfunction

    // Offers one item, waits for its transfer and records the expected result.
    task automatic send_item(input plan_row_t row);
        swarm_result_t r;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        func      <= row.item.func;
        particle  <= row.item.particle;
        dimension <= row.item.dimension;
        rand_a    <= row.item.rand_a;
        rand_b    <= row.item.rand_b;
        cost      <= row.item.cost;
        do
            @(posedge clk);
        while (in_stall);
        swarm_update(row.item, r);
        if (row.typed)
        begin
            r.pos   = row.res.pos;
            r.bpos  = row.res.bpos;
            r.bcost = row.res.bcost;
            r.pimp  = row.res.pimp;
            r.gimp  = row.res.gimp;
        end
        awaited_results.push_back(r);
    endtask

    // Holds the input back until every outstanding result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_bounds(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_LOWER_BOUND;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_UPPER_BOUND;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        lo_bound = lo;
        hi_bound = hi;
    endtask

    // Receiver: random stalls, and each result transfer is checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                errors++;
            end
            else
            begin
                oldest = awaited_results.pop_front();
                if (position !== oldest.pos)
                begin
                    $error("position: expected %h, got %h", oldest.pos, position);
                    errors++;
                end
                if (oldest.bpos_known && best_position !== oldest.bpos)
                begin
                    $error("best_position: expected %h, got %h", oldest.bpos, best_position);
                    errors++;
                end
                if (best_cost !== oldest.bcost)
                begin
                    $error("best_cost: expected %h, got %h", oldest.bcost, best_cost);
                    errors++;
                end
                if (personal_improved !== oldest.pimp)
                begin
                    $error("personal_improved: expected %b, got %b",
                           oldest.pimp, personal_improved);
                    errors++;
                end
                if (global_improved !== oldest.gimp)
                begin
                    $error("global_improved: expected %b, got %b",
                           oldest.gimp, global_improved);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: directed table at the reset bounds, then random phases.
    initial
    begin
        plan_row_t         row;
        logic [CFG_W-1:0]  lo;
        logic [CFG_W-1:0]  hi;
        int                ph;
        int                quota;
        int                done;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Items that touch no stored entry, then a fully seeded particle.
        add_row(FUNC_START, 0, 7, 16'h0000, 16'h0000, 32'h0, 1, '0, '0, '1, 0, 0);
        add_row(3'd7, 63, 6, 16'hFFFF, 16'hFFFF, '1, 1, '0, '0, '1, 0, 0);
        add_row(3'd5, 1, 5, 16'h0000, 16'h0000, 32'h0, 1, '0, '0, '1, 0, 0);
        add_row(FUNC_SEED, 0, 0, 16'h0000, 16'h0000, 32'h0, 1, 24'd3277, '0, '1, 0, 0);
        add_row(FUNC_SEED, 0, 1, 16'hFFFF, 16'h0000, 32'h0, 1, 24'd65535, '0, '1, 0, 0);
        add_row(FUNC_SEED, 0, 2, 16'h8000, 16'hFFFF, 32'h0);
        add_row(FUNC_SEED, 0, 3, 16'h1234, 16'h0000, 32'h0);
        add_row(FUNC_SEED, 0, 4, 16'h00FF, 16'h0000, 32'h0);
        // Dimension out of range: the seed is dropped.
        add_row(FUNC_SEED, 2, 7, 16'hFFFF, 16'h0000, 32'h0, 1, '0, '0, '1, 0, 0);
        // An infeasible cost never becomes the global best.
        add_row(FUNC_SEED_COST, 0, 7, 16'h0000, 16'h0000, '1, 1, '0, '0, '1, 1, 0);
        add_row(FUNC_SEED_COST, 0, 6, 16'h0000, 16'h0000, 32'd1000, 1, '0, '0, 32'd1000, 1, 1);
        add_row(FUNC_SEED, 63, 0, 16'hFFFF, 16'h0000, 32'h0);
        add_row(FUNC_SEED, 63, 1, 16'h0001, 16'h0000, 32'h0);
        add_row(FUNC_SEED, 63, 2, 16'hC000, 16'h0000, 32'h0);
        add_row(FUNC_SEED, 63, 3, 16'h4000, 16'h0000, 32'h0);
        add_row(FUNC_SEED, 63, 4, 16'h0000, 16'h0000, 32'h0);
        add_row(FUNC_SEED_COST, 63, 2, 16'h0000, 16'h0000, 32'h0);
        add_row(FUNC_MOVE, 0, 0, 16'hFFFF, 16'hFFFF, 32'h0);
        add_row(FUNC_MOVE, 63, 1, 16'h0000, 16'h0000, 32'h0);
        add_row(FUNC_MOVE, 0, 4, 16'hFFFF, 16'h0000, 32'h0);
        add_row(FUNC_MOVE, 0, 5, 16'h0001, 16'h0001, 32'h0, 1, '0, '0, 32'h0, 0, 0);
        add_row(FUNC_MOVE_COST, 0, 1, 16'h0000, 16'h0000, '1);
        add_row(FUNC_MOVE_COST, 0, 0, 16'h0000, 16'h0000, 32'd500);
        // Equal cost is not an improvement.
        add_row(FUNC_MOVE_COST, 63, 3, 16'h0000, 16'h0000, 32'h0);
        add_row(FUNC_START, 63, 3, 16'h0000, 16'h0000, 32'h0);

        send_idle_pct = 34;
        recv_idle_pct = 54;
        foreach (directed_plan[i])
            send_item(directed_plan[i]);

        for (ph = 1; ph <= 4; ph++)
        begin
            case (ph)
                1:
                begin
                    lo    = '0;
                    hi    = '1;
                    quota = 110;
                end
                2:
                begin
                    lo    = '1;
                    hi    = '0;
                    quota = 50;
                end
                3:
                begin
                    lo    = CFG_W'($urandom_range(0, 24'h7FFFFF));
                    hi    = CFG_W'($urandom_range(lo, 24'hFFFFFF));
                    quota = 120;
                end
                default:
                begin
                    lo    = CFG_W'($urandom);
                    hi    = CFG_W'($urandom);
                    quota = 120;
                end
            endcase
            set_bounds(lo, hi);
            send_idle_pct = (ph == 1) ? 34 : (ph < 4) ? 54 : 0;
            recv_idle_pct = (ph == 1) ? 54 : (ph < 4) ? 34 : 0;

            done = 0;
            while (done < quota)
            begin
                row.item  = pick_item();
                row.typed = 1'b0;
                send_item(row);
                // Items the engine drops do not count.
                if (row.item.func <= FUNC_MOVE_COST &&
                    !((row.item.func == FUNC_SEED || row.item.func == FUNC_MOVE) &&
                      row.item.dimension >= ND))
                    done++;
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
